// ----- hw/rtl/bm3_pkg.sv -----
package bm3_pkg;

    // frame size limits and window size
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIN        = 3;

    // field widths of the ports
    localparam int MODE_BITS    = 2;
    localparam int WIDTH_FIELD  = 11;
    localparam int HEIGHT_FIELD = 13;
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int CMD_BITS     = 1;
    localparam int PIX_BITS     = 8;

    // internal widths
    localparam int WD_BITS   = $clog2(MAX_WIDTH + 1);   // effective width 1..MAX_WIDTH
    localparam int HT_BITS   = $clog2(MAX_HEIGHT + 1);  // effective height 1..MAX_HEIGHT
    localparam int COL_BITS  = $clog2(MAX_WIDTH);       // column 0..MAX_WIDTH-1
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT + 3);  // row, runs a little past the frame
    localparam int WARM_BITS = $clog2(MAX_WIDTH + 2);   // pipeline fill count 0..W+1
    localparam int LINE_BITS = 2;                       // two rows held per column

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam logic [PIX_BITS-1:0] FG_VALUE = PIX_BITS'(255);

    // register indices
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = CFG_IDX_BITS'(2);

    // request commands
    localparam logic [CMD_BITS-1:0] CMD_PIXEL = 1'b0;
    localparam logic [CMD_BITS-1:0] CMD_DRAIN = 1'b1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ERODE,
        MODE_DILATE,
        MODE_OPEN,
        MODE_CLOSE
    } t_mode;

    // 3x3 neighbourhood, [row][col], row 0 oldest (top), col 0 oldest (left)
    typedef logic [WIN-1:0][WIN-1:0] t_win;

    // raster position
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_pos;

    // facts about one window centre
    typedef struct packed {
        logic emit;       // centre lies inside the frame
        logic top;        // row above is inside the image
        logic bottom;     // row below is inside the image
        logic left;
        logic right;
        logic row_end;
        logic frame_end;
    } t_ctr;

    // side information that travels with a request through the window stages
    typedef struct packed {
        logic                a_live;
        t_ctr                a;
        logic                b_live;
        t_ctr                b;
        logic [COL_BITS-1:0] a_col;
    } t_tag;

    // one result
    typedef struct packed {
        logic fg;
        logic row_end;
        logic frame_end;
    } t_res;

endpackage

// ----- hw/rtl/bm3_ram.sv -----
module bm3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // simple dual port, read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/bm3_win.sv -----
module bm3_win (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_load,
    input  logic                         i_fg,
    input  logic [bm3_pkg::COL_BITS-1:0] i_col,
    input  bm3_pkg::t_tag                i_tag,
    output logic                         o_valid,
    output bm3_pkg::t_win                o_win,
    output bm3_pkg::t_tag                o_tag
);
    import bm3_pkg::*;

    logic                 r_s1_valid;
    logic                 r_s1_fg;
    logic [COL_BITS-1:0]  r_s1_col;
    t_tag                 r_s1_tag;
    logic                 r_s2_valid;
    t_tag                 r_s2_tag;
    t_win                 r_win;
    logic                 r_fwd;
    logic [LINE_BITS-1:0] r_fwd_data;

    logic                 rd_en;
    logic                 wr_en;
    logic [LINE_BITS-1:0] ram_rd;
    logic [LINE_BITS-1:0] line_rd;
    logic [LINE_BITS-1:0] wr_data;

    // line store: per column, bit 1 is one row up, bit 0 two rows up
    assign rd_en   = i_en && i_load;
    assign wr_en   = i_en && r_s1_valid;
    assign line_rd = r_fwd ? r_fwd_data : ram_rd;
    assign wr_data = {r_s1_fg, line_rd[1]};

    bm3_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .i_re      (rd_en),
        .i_rd_addr (i_col),
        .o_rd_data (ram_rd)
    );

    // one-pixel rows: the next read hits the column being written this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (rd_en) begin
            r_fwd <= wr_en && (r_s1_col == i_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_fwd_data <= wr_data;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_load;
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_fg  <= i_fg;
            r_s1_col <= i_col;
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
        end
    end

    // window shifts left, newest column enters on the right
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int r = 0; r < WIN; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_rd[0];
            r_win[1][2] <= line_rd[1];
            r_win[2][2] <= r_s1_fg;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_win   = r_win;
    assign o_tag   = r_s2_tag;

endmodule

// ----- hw/rtl/binary_morphology_3x3.sv -----
// 3x3 binary morphology (erode, dilate, open, close) on a raster pixel stream.
// One request is taken every clock; the block never throttles the input except when
// both the output register and its skid stage hold unread results. Each request
// passes through a window stage of two registers (line store read, window shift)
// and then the output register; open and close chain two such window stages. A
// pixel's result is completed by the request W+1 places later in the stream
// (W = row width), or 2W+2 places later in open and close, so after the W*H pixels
// of a frame the source sends W+1 (or 2W+2) drain requests to flush the tail;
// frame_end marks the last result, after which the next request starts a new
// frame. Drain requests sent before the frame is complete are dropped, and pixels
// sent after it act as drains. A register write restarts the frame and must be
// made while the block is idle. Width and height are clamped to 1..1024 and
// 1..4096. Line stores hold two frame rows per window stage and need no clearing
// after reset.
module binary_morphology_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bm3_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bm3_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bm3_pkg::CMD_BITS-1:0]     i_cmd,
    input  logic [bm3_pkg::PIX_BITS-1:0]     i_pixel_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bm3_pkg::PIX_BITS-1:0]     o_pixel_out,
    output logic                             o_row_end,
    output logic                             o_frame_end
);
    import bm3_pkg::*;

    // clamp a width field to 1..MAX_WIDTH
    function automatic logic [WD_BITS-1:0] sat_width(logic [WIDTH_FIELD-1:0] v);
        int unsigned x;
        x = v;
        if (x == 0) x = 1;
        if (x > MAX_WIDTH) x = MAX_WIDTH;
        return WD_BITS'(x);
    endfunction

    // clamp a height field to 1..MAX_HEIGHT
    function automatic logic [HT_BITS-1:0] sat_height(logic [HEIGHT_FIELD-1:0] v);
        int unsigned x;
        x = v;
        if (x == 0) x = 1;
        if (x > MAX_HEIGHT) x = MAX_HEIGHT;
        return HT_BITS'(x);
    endfunction

    // raster step
    function automatic t_pos next_pos(t_pos p, logic [COL_BITS-1:0] w_last);
        t_pos n;
        n = p;
        if (p.col == w_last) begin
            n.col = '0;
            n.row = p.row + 1'b1;
        end else begin
            n.col = p.col + 1'b1;
        end
        return n;
    endfunction

    // border and end flags for a window centre
    function automatic t_ctr centre_info(t_pos p, logic [COL_BITS-1:0] w_last,
                                         logic [ROW_BITS-1:0] h_last,
                                         logic [ROW_BITS-1:0] h_rows);
        t_ctr c;
        c.emit      = p.row < h_rows;
        c.top       = p.row != '0;
        c.bottom    = p.row < h_last;
        c.left      = p.col != '0;
        c.right     = p.col != w_last;
        c.row_end   = p.col == w_last;
        c.frame_end = (p.row == h_last) && (p.col == w_last);
        return c;
    endfunction

    // AND (erode) or OR (dilate) over the neighbours inside the image
    function automatic logic morph(t_win win, t_ctr c, logic grow);
        logic [WIN-1:0] row_ok;
        logic [WIN-1:0] col_ok;
        t_win           m;
        logic           acc;
        row_ok = {c.bottom, 1'b1, c.top};
        col_ok = {c.right, 1'b1, c.left};
        for (int r = 0; r < WIN; r++) begin
            for (int k = 0; k < WIN; k++) begin
                m[r][k] = row_ok[r] & col_ok[k];
            end
        end
        if (grow) acc = |(win & m);
        else      acc = &(win | ~m);
        return acc;
    endfunction

    t_mode                r_mode;
    logic [WD_BITS-1:0]   r_w;
    logic [HT_BITS-1:0]   r_h;
    t_pos                 r_p;
    t_pos                 r_a_pos;
    t_pos                 r_b_pos;
    logic [WARM_BITS-1:0] r_a_warm;
    logic [WARM_BITS-1:0] r_b_warm;
    logic                 r_out_valid;
    t_res                 r_out;
    logic                 r_skid_valid;
    t_res                 r_skid;

    t_pos                 n_p;
    t_pos                 n_a_pos;
    t_pos                 n_b_pos;
    logic [WARM_BITS-1:0] n_a_warm;
    logic [WARM_BITS-1:0] n_b_warm;
    logic                 n_out_valid;
    logic                 n_skid_valid;

    logic [COL_BITS-1:0]  w_last;
    logic [ROW_BITS-1:0]  h_rows;
    logic [ROW_BITS-1:0]  h_last;
    logic [WARM_BITS-1:0] warm_full;
    logic                 core_en;
    logic                 accept;
    logic                 in_frame;
    logic                 step;
    logic                 two_pass;
    logic                 a_live;
    logic                 b_live;
    t_ctr                 a_info;
    t_ctr                 b_info;
    logic                 in_fg;
    logic                 fe_step;
    logic                 cfg_hit;
    t_tag                 in_tag;

    logic                 a_valid;
    t_win                 a_win;
    t_tag                 a_tag;
    logic                 a_res;
    logic                 b_load;
    logic                 b_valid;
    t_win                 b_win;
    t_tag                 b_tag;
    logic                 b_res;
    logic                 res_valid;
    t_res                 res;
    logic                 load_out;
    logic                 load_skid;
    logic                 out_from_skid;

    // frame geometry
    assign w_last    = COL_BITS'(r_w - 1'b1);
    assign h_rows    = ROW_BITS'(r_h);
    assign h_last    = h_rows - 1'b1;
    assign warm_full = WARM_BITS'(r_w) + WARM_BITS'(1);
    assign two_pass  = (r_mode == MODE_OPEN) || (r_mode == MODE_CLOSE);

    // input handshake
    assign core_en    = !r_skid_valid;
    assign o_in_ready = core_en;
    assign accept     = i_in_valid && o_in_ready;
    assign in_frame   = r_p.row < h_rows;
    assign step       = accept && !(in_frame && (i_cmd == CMD_DRAIN));
    assign cfg_hit    = i_cfg_we && ((i_cfg_index == REG_MODE) ||
                                     (i_cfg_index == REG_WIDTH) ||
                                     (i_cfg_index == REG_HEIGHT));

    // window centres for this step
    assign a_live  = r_a_warm == warm_full;
    assign b_live  = a_live && (r_b_warm == warm_full);
    assign a_info  = centre_info(r_a_pos, w_last, h_last, h_rows);
    assign b_info  = centre_info(r_b_pos, w_last, h_last, h_rows);
    assign fe_step = step && (two_pass ? (b_live && b_info.emit && b_info.frame_end)
                                       : (a_live && a_info.emit && a_info.frame_end));

    // pixel to foreground bit, close works on the inverted image
    always_comb begin
        if (!in_frame) begin
            in_fg = 1'b0;
        end else if (r_mode == MODE_CLOSE) begin
            in_fg = i_pixel_in == '0;
        end else begin
            in_fg = i_pixel_in == FG_VALUE;
        end
    end

    always_comb begin
        in_tag.a_live = a_live;
        in_tag.a      = a_info;
        in_tag.b_live = b_live;
        in_tag.b      = b_info;
        in_tag.a_col  = r_a_pos.col;
    end

    // position counters
    always_comb begin
        n_p      = r_p;
        n_a_pos  = r_a_pos;
        n_b_pos  = r_b_pos;
        n_a_warm = r_a_warm;
        n_b_warm = r_b_warm;
        if (step) begin
            n_p = next_pos(r_p, w_last);
            if (!a_live) begin
                n_a_warm = r_a_warm + 1'b1;
            end else begin
                n_a_pos = next_pos(r_a_pos, w_last);
                if (!b_live) begin
                    n_b_warm = r_b_warm + 1'b1;
                end else begin
                    n_b_pos = next_pos(r_b_pos, w_last);
                end
            end
        end
        if (fe_step || cfg_hit) begin
            n_p      = '0;
            n_a_pos  = '0;
            n_b_pos  = '0;
            n_a_warm = '0;
            n_b_warm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p      <= '0;
            r_a_pos  <= '0;
            r_b_pos  <= '0;
            r_a_warm <= '0;
            r_b_warm <= '0;
        end else begin
            r_p      <= n_p;
            r_a_pos  <= n_a_pos;
            r_b_pos  <= n_b_pos;
            r_a_warm <= n_a_warm;
            r_b_warm <= n_b_warm;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ERODE;
            r_w    <= sat_width(WIDTH_FIELD'(RESET_WIDTH));
            r_h    <= sat_height(HEIGHT_FIELD'(RESET_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:   r_mode <= t_mode'(i_cfg_data[MODE_BITS-1:0]);
                REG_WIDTH:  r_w    <= sat_width(i_cfg_data[WIDTH_FIELD-1:0]);
                REG_HEIGHT: r_h    <= sat_height(i_cfg_data[HEIGHT_FIELD-1:0]);
                default:    ;
            endcase
        end
    end

    // first window stage: erode, or dilate in dilate mode
    bm3_win u_stage_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (core_en),
        .i_load  (step),
        .i_fg    (in_fg),
        .i_col   (r_p.col),
        .i_tag   (in_tag),
        .o_valid (a_valid),
        .o_win   (a_win),
        .o_tag   (a_tag)
    );

    assign a_res  = morph(a_win, a_tag.a, r_mode == MODE_DILATE);
    assign b_load = a_valid && a_tag.a_live && two_pass;

    // second window stage: dilate for open and close
    bm3_win u_stage_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (core_en),
        .i_load  (b_load),
        .i_fg    (a_res),
        .i_col   (a_tag.a_col),
        .i_tag   (a_tag),
        .o_valid (b_valid),
        .o_win   (b_win),
        .o_tag   (b_tag)
    );

    assign b_res = morph(b_win, b_tag.b, 1'b1) ^ (r_mode == MODE_CLOSE);

    // pick the result of the last stage in use
    always_comb begin
        if (two_pass) begin
            res_valid     = b_valid && b_tag.b_live && b_tag.b.emit;
            res.fg        = b_res;
            res.row_end   = b_tag.b.row_end;
            res.frame_end = b_tag.b.frame_end;
        end else begin
            res_valid     = a_valid && a_tag.a_live && a_tag.a.emit;
            res.fg        = a_res;
            res.row_end   = a_tag.a.row_end;
            res.frame_end = a_tag.a.frame_end;
        end
    end

    // output register with skid stage
    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        if (r_skid_valid) begin
            if (i_out_ready) begin
                out_from_skid = 1'b1;
                n_skid_valid  = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || i_out_ready) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_from_skid) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= res;
        end
        if (load_skid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out.fg ? FG_VALUE : '0;
    assign o_row_end   = r_out.row_end;
    assign o_frame_end = r_out.frame_end;

    // skid stage only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full with empty output register");

    // last pixel of a frame is also last of its row
    a_frame_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    // frame completion restarts the raster counters
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_step |=> ((r_p == '0) && (r_a_warm == '0) && (r_b_warm == '0)))
        else $error("counters not cleared after frame end");

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bm3_pkg::*;

    // line store length of the predictor: two rows plus a little slack
    localparam int LINE_SLOTS   = 2 * MAX_WIDTH + 3;
    // cycles the pipeline may still be busy after the last expected pixel
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1100;
    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                row_end;
        logic                frame_end;
    } morph_result_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [CMD_BITS-1:0]     i_cmd;
    logic [PIX_BITS-1:0]     i_pixel_in;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [PIX_BITS-1:0]     o_pixel_out;
    logic                    o_row_end;
    logic                    o_frame_end;

    binary_morphology_3x3 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    // predictor state
    t_mode                   cur_mode;
    logic [WIDTH_FIELD-1:0]  cfg_width;
    logic [HEIGHT_FIELD-1:0] cfg_height;
    int unsigned             stream_pos;
    bit                      in_bits[LINE_SLOTS];
    bit                      eroded_bits[LINE_SLOTS];
    bit                      frame_closed;
    morph_result_t           expected_pixels[$];

    // bookkeeping shared by the processes
    int unsigned stream_requests;
    int          mismatches;
    int          send_idle_pct;
    int          out_stall_pct;
    bit          hold_request;
    bit          offering;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------------------

    function automatic int frame_cols();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int frame_rows();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(cfg_height);
    endfunction

    // AND (shrink) or OR (grow) over the 3x3 neighbours that lie inside the image
    function automatic bit window_value(input bit from_eroded, input int q, input int w,
                                        input int h, input bit grow);
        int r, c, rr, cc, dr, dc, idx;
        bit acc, v;
        r   = q / w;
        c   = q % w;
        acc = !grow;
        for (dr = -1; dr <= 1; dr++) begin
            rr = r + dr;
            if (rr < 0 || rr >= h) continue;
            for (dc = -1; dc <= 1; dc++) begin
                cc = c + dc;
                if (cc < 0 || cc >= w) continue;
                idx = (rr * w + cc) % LINE_SLOTS;
                v   = from_eroded ? eroded_bits[idx] : in_bits[idx];
                if (grow) acc = acc | v;
                else acc = acc & v;
            end
        end
        return acc;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] data);
        case (idx)
            REG_MODE:   cur_mode   = t_mode'(data[MODE_BITS-1:0]);
            REG_WIDTH:  cfg_width  = data[WIDTH_FIELD-1:0];
            REG_HEIGHT: cfg_height = data[HEIGHT_FIELD-1:0];
            default:    return;
        endcase
        stream_pos = 0;
    endfunction

    // works out the pixel, if any, that an accepted request completes
    function automatic void predict_morphology(input logic [CMD_BITS-1:0] cmd,
                                               input logic [PIX_BITS-1:0] pix);
        int            w, h, frame, lag, q, n;
        bit            b;
        morph_result_t r;
        w     = frame_cols();
        h     = frame_rows();
        frame = w * h;
        lag   = w + 2;
        if (stream_pos < frame) begin
            // drain before the frame is complete: dropped
            if (cmd != CMD_PIXEL) return;
            if (cur_mode == MODE_CLOSE) b = (pix == 0);
            else b = (pix == FG_VALUE);
            in_bits[stream_pos % LINE_SLOTS] = b;
        end
        stream_requests++;
        stream_pos++;
        n = stream_pos;
        if (n < lag) return;
        q = n - lag;
        if (cur_mode == MODE_OPEN || cur_mode == MODE_CLOSE) begin
            if (q < frame) eroded_bits[q % LINE_SLOTS] = window_value(1'b0, q, w, h, 1'b0);
            if (q + 1 < lag) return;
            q = q + 1 - lag;
            if (q >= frame) return;
            b = window_value(1'b1, q, w, h, 1'b1);
            if (cur_mode == MODE_CLOSE) b = !b;
        end else begin
            if (q >= frame) return;
            b = window_value(1'b0, q, w, h, cur_mode == MODE_DILATE);
        end
        r.pixel     = b ? FG_VALUE : '0;
        r.row_end   = (q % w == w - 1);
        r.frame_end = (q == frame - 1);
        if (r.frame_end) begin
            stream_pos   = 0;
            frame_closed = 1'b1;
        end
        expected_pixels.push_back(r);
    endfunction

    // ---------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------

    // mostly no gap, else a short one, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(12, 48);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [PIX_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return FG_VALUE;
            4, 5, 6:    return '0;
            7:          return PIX_BITS'($urandom_range(1, 254));
            default:    return PIX_BITS'($urandom);
        endcase
    endfunction

    // size register value: usually small, sometimes larger, now and then zero
    function automatic int pick_size(input int typical, input int big);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(typical + 1, big);
        return $urandom_range(1, typical);
    endfunction

    task automatic send_req(input logic [CMD_BITS-1:0] cmd, input logic [PIX_BITS-1:0] pix);
        int gap;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_pixel_in <= pix;
        offering   = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_morphology(cmd, pix);
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            offering   = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering, let every expected pixel arrive and the pipeline settle
    task automatic wait_idle();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering   = 1'b0;
        end
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_BITS'(value);
        @(posedge i_clk);
        apply_config(idx, CFG_BITS'(value));
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input t_mode m, input int unsigned w, input int unsigned h);
        write_reg(REG_MODE, m);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // tail of the frame: drains mixed with late pixels until frame_end is due
    task automatic flush_frame();
        while (!frame_closed) begin
            if ($urandom_range(0, 3) == 0) send_req(CMD_PIXEL, rand_pixel());
            else send_req(CMD_DRAIN, PIX_BITS'($urandom));
        end
    endtask

    task automatic random_frame();
        int npix, i;
        npix         = frame_cols() * frame_rows();
        frame_closed = 1'b0;
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(0, 11) == 0) send_req(CMD_DRAIN, PIX_BITS'($urandom));
            if ($urandom_range(0, 199) == 0) wait_idle();
            send_req(CMD_PIXEL, rand_pixel());
        end
        flush_frame();
    endtask

    // ---------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------

    task automatic test_directed();
        send_idle_pct = 0;
        out_stall_pct = 0;
        // erode on 3x2, a drain mid-frame is dropped, a late pixel acts as drain
        set_frame(MODE_ERODE, 3, 2);
        frame_closed = 1'b0;
        send_req(CMD_PIXEL, 8'd255);
        send_req(CMD_PIXEL, 8'd255);
        send_req(CMD_DRAIN, 8'd255);
        send_req(CMD_PIXEL, 8'd254);
        send_req(CMD_PIXEL, 8'd255);
        send_req(CMD_PIXEL, 8'd255);
        send_req(CMD_PIXEL, 8'd0);
        send_req(CMD_PIXEL, 8'd255);
        flush_frame();
        // zero sizes clamp to 1x1; close takes any nonzero value as foreground
        set_frame(MODE_CLOSE, 0, 0);
        frame_closed = 1'b0;
        send_req(CMD_PIXEL, 8'd1);
        flush_frame();
        set_frame(MODE_DILATE, 2, 2);
        frame_closed = 1'b0;
        send_req(CMD_PIXEL, 8'd0);
        send_req(CMD_PIXEL, 8'd128);
        send_req(CMD_PIXEL, 8'd0);
        send_req(CMD_PIXEL, 8'd255);
        flush_frame();
        set_frame(MODE_OPEN, 3, 1);
        frame_closed = 1'b0;
        send_req(CMD_PIXEL, 8'd255);
        send_req(CMD_PIXEL, 8'd255);
        send_req(CMD_PIXEL, 8'd0);
        flush_frame();
    endtask

    // a register write between requests throws away the partial frame
    task automatic test_config_abort();
        int i;
        send_idle_pct = 20;
        out_stall_pct = 20;
        set_frame(MODE_DILATE, 5, 4);
        frame_closed = 1'b0;
        for (i = 0; i < 7; i++) send_req(CMD_PIXEL, rand_pixel());
        write_reg(REG_HEIGHT, 4);
        random_frame();
        write_reg(REG_SPARE, 8191);
        random_frame();
    endtask

    // saturated and extreme frame sizes, one frame each
    task automatic test_size_extremes();
        send_idle_pct = 10;
        out_stall_pct = 10;
        set_frame(MODE_OPEN, 2047, 1);
        random_frame();
        set_frame(MODE_ERODE, 1024, 2);
        random_frame();
        set_frame(MODE_CLOSE, 1, 8191);
        random_frame();
        set_frame(MODE_DILATE, 1, 4096);
        random_frame();
        // bits above the width field are dropped
        set_frame(MODE_ERODE, 13'h1802, 3);
        random_frame();
    endtask

    // output held off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        set_frame(MODE_OPEN, 16, 6);
        hold_request = 1'b1;
        random_frame();
        wait_idle();
        set_frame(MODE_CLOSE, 9, 5);
        hold_request = 1'b1;
        random_frame();
    endtask

    task automatic test_random_frames();
        int unsigned target;
        target = stream_requests + RANDOM_ITEMS;
        write_reg(REG_WIDTH, pick_size(12, 48));
        write_reg(REG_HEIGHT, pick_size(8, 24));
        while (stream_requests < target) begin
            case ($urandom_range(0, 3))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 15;
                default: send_idle_pct = 40;
            endcase
            case ($urandom_range(0, 3))
                0:       out_stall_pct = 0;
                1:       out_stall_pct = 15;
                default: out_stall_pct = 40;
            endcase
            if ($urandom_range(0, 9) < 7) write_reg(REG_MODE, $urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) write_reg(REG_WIDTH, pick_size(12, 48));
            if ($urandom_range(0, 1) == 1) write_reg(REG_HEIGHT, pick_size(8, 24));
            if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, $urandom_range(0, 8191));
            random_frame();
        end
    endtask

    // ---------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_PIXEL;
        i_pixel_in  <= '0;
        offering        = 1'b0;
        hold_request    = 1'b0;
        send_idle_pct   = 0;
        out_stall_pct   = 0;
        mismatches      = 0;
        stream_requests = 0;
        frame_closed    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_mode   = MODE_ERODE;
        cfg_width  = WIDTH_FIELD'(RESET_WIDTH);
        cfg_height = HEIGHT_FIELD'(RESET_HEIGHT);
        stream_pos = 0;

        test_directed();
        test_config_abort();
        test_size_extremes();
        test_back_pressure();
        test_random_frames();

        wait_idle();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // output side: random stalls, plus the long hold-off when asked
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                stall = pick_gap(out_stall_pct);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // compare each accepted pixel with the oldest expected one
    always @(posedge i_clk) begin : result_check
        morph_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel_out=%0d row_end=%0d frame_end=%0d",
                         $time, o_pixel_out, o_row_end, o_frame_end);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_out !== want.pixel) begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, want.pixel, o_pixel_out);
                    mismatches++;
                end
                if (o_row_end !== want.row_end) begin
                    $display("%0t: row_end expected %0d actual %0d",
                             $time, want.row_end, o_row_end);
                    mismatches++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0d actual %0d",
                             $time, want.frame_end, o_frame_end);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any request, result or register write
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no progress for %0d cycles, %0d pixels outstanding",
                 $time, QUIET_LIMIT, expected_pixels.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bm3_pkg.sv
hw/rtl/bm3_ram.sv
hw/rtl/bm3_win.sv
hw/rtl/binary_morphology_3x3.sv
test/testbench.sv
